// ===== rtl/core/lrupr_pkg.sv =====
package lrupr_pkg;

  // Register indexes, selected by paddr[2]
  typedef enum logic {
    REG_FRAMES_USED = 1'b0,
    REG_NONE        = 1'b1
  } reg_idx_e;

  localparam logic [2:0]  FRAMES_USED_RESET = 3'd4;
  localparam logic [15:0] FAULT_MAX         = 16'hFFFF;

  typedef struct packed {
    logic [7:0] page;
    logic       last_ref;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  frame_slot;
    logic        evicted_valid;
    logic [7:0]  evicted_page;
    logic [15:0] fault_total;
    logic        run_end;
  } rsp_t;

  // Update strobe toward the frame table
  typedef struct packed {
    logic step;
    logic last;
  } step_t;

endpackage

// ===== rtl/core/lrupr_frame_table.sv =====
module lrupr_frame_table #(
  parameter int FRAMES    = 4,
  parameter int PAGE_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lrupr_pkg::step_t     ctrl_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic [2:0]           frames_used_i,
  output lrupr_pkg::rsp_t      rsp_o
);

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RW = IW;
  localparam logic [RW-1:0] RANK_MAX = RW'(FRAMES - 1);

  logic [PAGE_BITS-1:0] page_q [FRAMES];
  logic [PAGE_BITS-1:0] page_d [FRAMES];
  logic [RW-1:0]        rank_q [FRAMES];
  logic [RW-1:0]        rank_d [FRAMES];
  logic [FRAMES-1:0]    valid_q, valid_d;
  logic [15:0]          fault_q, fault_d;

  logic [FRAMES-1:0]    active, match, free, win;
  logic [2:0]           fu_eff;
  logic [IW-1:0]        hit_slot, free_slot, vic_slot, slot;
  logic                 hit, have_free, ev_valid;
  logic [PAGE_BITS-1:0] ev_page;
  logic [RW-1:0]        slot_rank;
  logic [31:0]          slot_ext, ev_ext;

  assign fu_eff = (frames_used_i == 3'd0) ? 3'd1 : frames_used_i;

  // Per-frame compare and LRU victim vote
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      active[i] = (32'(i) < 32'(fu_eff));
      match[i]  = active[i] && valid_q[i] && (page_q[i] == page_i);
      free[i]   = active[i] && !valid_q[i];
      win[i]    = active[i] && (rank_q[i] != '0);
      for (int j = 0; j < FRAMES; j++) begin
        if (active[j] && j < i && !(rank_q[j] < rank_q[i])) begin
          win[i] = 1'b0;
        end
        if (active[j] && j > i && rank_q[j] > rank_q[i]) begin
          win[i] = 1'b0;
        end
      end
    end
  end

  // Lowest index wins
  always_comb begin
    hit_slot  = '0;
    free_slot = '0;
    vic_slot  = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_slot = IW'(i);
      end
      if (free[i]) begin
        free_slot = IW'(i);
      end
      if (win[i]) begin
        vic_slot = IW'(i);
      end
    end
  end

  assign hit       = |match;
  assign have_free = |free;
  assign slot      = hit ? hit_slot : (have_free ? free_slot : vic_slot);
  assign ev_valid  = !hit && !have_free;
  assign ev_page   = ev_valid ? page_q[slot] : '0;
  assign slot_rank = rank_q[slot];

  always_comb begin
    fault_d = fault_q;
    if (!hit && fault_q != lrupr_pkg::FAULT_MAX) begin
      fault_d = fault_q + 16'd1;
    end
  end

  always_comb begin
    valid_d = valid_q;
    for (int i = 0; i < FRAMES; i++) begin
      page_d[i] = page_q[i];
      rank_d[i] = rank_q[i];
      if (IW'(i) == slot) begin
        rank_d[i] = '0;
        if (!hit) begin
          page_d[i]  = page_i;
          valid_d[i] = 1'b1;
        end
      end else if (active[i] && valid_q[i]) begin
        if (hit && rank_q[i] < slot_rank) begin
          rank_d[i] = rank_q[i] + RW'(1);
        end else if (!hit && rank_q[i] < RANK_MAX) begin
          rank_d[i] = rank_q[i] + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fault_q <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        page_q[i] <= '0;
        rank_q[i] <= '0;
      end
    end else if (ctrl_i.step) begin
      if (ctrl_i.last) begin
        valid_q <= '0;
        fault_q <= '0;
        for (int i = 0; i < FRAMES; i++) begin
          page_q[i] <= '0;
          rank_q[i] <= '0;
        end
      end else begin
        valid_q <= valid_d;
        fault_q <= fault_d;
        for (int i = 0; i < FRAMES; i++) begin
          page_q[i] <= page_d[i];
          rank_q[i] <= rank_d[i];
        end
      end
    end
  end

  assign slot_ext = 32'(slot);
  assign ev_ext   = 32'(ev_page);

  always_comb begin
    rsp_o.hit           = hit;
    rsp_o.frame_slot    = slot_ext[1:0];
    rsp_o.evicted_valid = ev_valid;
    rsp_o.evicted_page  = ev_ext[7:0];
    rsp_o.fault_total   = fault_d;
    rsp_o.run_end       = ctrl_i.last;
  end

endmodule

// ===== rtl/core/lru_page_replacement_unit.sv =====
// LRU page replacement unit.
// A request passes the input register, then the result register, before its result is valid.
// Throughput: one request per cycle while the result side is not stalled; frame compare,
// victim vote and rank update all resolve combinationally between the input and result registers.
// Reset (rst_ni low, async): all frames empty, ranks and fault count zero,
// frames_used = 4, both pipeline registers empty.
module lru_page_replacement_unit #(
  parameter int FRAMES    = 4,
  parameter int PAGE_BITS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // request channel
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  lrupr_pkg::req_t in_req_i,
  // result channel
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output lrupr_pkg::rsp_t out_rsp_o,
  // configuration port
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  // ---------------------------------------------------------------------
  // Configuration register. paddr[2] selects the register; low bits are
  // byte offsets within the word and are ignored.
  // ---------------------------------------------------------------------
  logic [2:0] frames_used_q;
  logic       cfg_write;
  lrupr_pkg::reg_idx_e reg_sel;

  assign pready    = 1'b1;
  assign reg_sel   = lrupr_pkg::reg_idx_e'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_used_q <= lrupr_pkg::FRAMES_USED_RESET;
    end else if (cfg_write && reg_sel == lrupr_pkg::REG_FRAMES_USED) begin
      frames_used_q <= pwdata[2:0];
    end
  end

  always_comb begin
    case (reg_sel)
      lrupr_pkg::REG_FRAMES_USED: prdata = {29'd0, frames_used_q};
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline control. The input register advances whenever the result
  // register is empty or its content is being taken this cycle, so requests
  // can enter every cycle and one more can wait behind a stalled result.
  // ---------------------------------------------------------------------
  logic            in_valid_q;
  lrupr_pkg::req_t in_q;
  logic            out_valid_q;
  lrupr_pkg::rsp_t out_q;
  logic            advance;
  logic            in_take;
  lrupr_pkg::step_t step;
  lrupr_pkg::rsp_t rsp;
  logic [31:0]     page_ext;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Hold the request while the result side is blocked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance || !in_valid_q) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_req_i;
    end
  end

  // Fire the frame table only when the result register can take the answer,
  // so each request updates state exactly once.
  assign step.step = in_valid_q && advance;
  assign step.last = in_q.last_ref;

  // Use only the low PAGE_BITS of the page number
  assign page_ext = 32'(in_q.page);

  lrupr_frame_table #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_table (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (step),
    .page_i        (page_ext[PAGE_BITS-1:0]),
    .frames_used_i (frames_used_q),
    .rsp_o         (rsp)
  );

  // Result register: load on each step, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step.step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step.step) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ===== rtl/core/lrupr_checker.sv =====
module lrupr_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input lrupr_pkg::rsp_t out_rsp_o
);

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.hit |-> !out_rsp_o.evicted_valid)
    else $error("hit reported with eviction");

  // Evicted page reads zero when nothing was replaced
  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.evicted_valid |-> out_rsp_o.evicted_page == 8'd0)
    else $error("evicted page nonzero without eviction");

  // Requests back up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request stalled while result side free");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

endmodule

bind lru_page_replacement_unit lrupr_checker u_lrupr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_FRAMES     = 4;
  localparam int MAX_IDLE       = 10;
  localparam int WATCHDOG_LIMIT = 400;
  // Fresh pages for the oversized frame count, enough to evict many times.
  localparam int OVERSIZE_REQS  = 40;
  localparam int RANDOM_REQS    = 1900;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [2:0] FRAMES_USED_ADDR = {lrupr_pkg::REG_FRAMES_USED, 2'b00};
  localparam logic [2:0] UNMAPPED_ADDR    = {lrupr_pkg::REG_NONE, 2'b00};

  // Tracks the frame table as the block should see it and holds the results
  // still owed by the block, oldest first.
  class page_table_scoreboard;
    bit [7:0]        frame_tag[NUM_FRAMES];
    bit              frame_busy[NUM_FRAMES];
    bit [1:0]        frame_age[NUM_FRAMES];
    bit [15:0]       run_faults;
    bit [2:0]        frames_cfg;
    lrupr_pkg::rsp_t owed[$];
    int              errors;

    function new();
      clear_run();
      frames_cfg = lrupr_pkg::FRAMES_USED_RESET;
      errors     = 0;
    endfunction

    function void clear_run();
      foreach (frame_tag[i]) begin
        frame_tag[i]  = '0;
        frame_busy[i] = 1'b0;
        frame_age[i]  = '0;
      end
      run_faults = '0;
    endfunction

    function void write_reg(logic [2:0] addr, logic [31:0] data);
      if (lrupr_pkg::reg_idx_e'(addr[2]) == lrupr_pkg::REG_FRAMES_USED)
        frames_cfg = data[2:0];
    endfunction

    // Zero counts as one frame, anything above the table size as all frames.
    function int active_frames();
      if (frames_cfg == 0) return 1;
      if (frames_cfg > NUM_FRAMES) return NUM_FRAMES;
      return frames_cfg;
    endfunction

    function string show(lrupr_pkg::rsp_t r);
      return $sformatf("hit=%0d slot=%0d evict=%0d/%0h faults=%0d end=%0d",
                       r.hit, r.frame_slot, r.evicted_valid, r.evicted_page,
                       r.fault_total, r.run_end);
    endfunction

    function void note_request(lrupr_pkg::req_t req);
      int              n;
      int              slot;
      bit              found;
      bit              spare;
      bit [1:0]        hit_age;
      bit [1:0]        oldest;
      lrupr_pkg::rsp_t res;
      n     = active_frames();
      slot  = 0;
      found = 1'b0;
      spare = 1'b0;
      res   = '0;
      for (int i = 0; i < n; i++) begin
        if (!found && frame_busy[i] && frame_tag[i] == req.page) begin
          slot  = i;
          found = 1'b1;
        end
      end
      if (found) begin
        hit_age = frame_age[slot];
        for (int i = 0; i < n; i++) begin
          if (frame_busy[i] && frame_age[i] < hit_age) frame_age[i]++;
        end
        frame_age[slot] = '0;
      end else begin
        if (run_faults != lrupr_pkg::FAULT_MAX) run_faults++;
        for (int i = 0; i < n; i++) begin
          if (!spare && !frame_busy[i]) begin
            slot  = i;
            spare = 1'b1;
          end
        end
        if (!spare) begin
          oldest = '0;
          for (int i = 0; i < n; i++) begin
            if (frame_age[i] > oldest) begin
              oldest = frame_age[i];
              slot   = i;
            end
          end
          res.evicted_valid = 1'b1;
          res.evicted_page  = frame_tag[slot];
        end
        for (int i = 0; i < n; i++) begin
          if (i != slot && frame_busy[i] && frame_age[i] < NUM_FRAMES - 1)
            frame_age[i]++;
        end
        frame_tag[slot]  = req.page;
        frame_busy[slot] = 1'b1;
        frame_age[slot]  = '0;
      end
      res.hit         = found;
      res.frame_slot  = 2'(slot);
      res.fault_total = run_faults;
      res.run_end     = req.last_ref;
      owed.push_back(res);
      if (req.last_ref) clear_run();
    endfunction

    function void check_result(lrupr_pkg::rsp_t got);
      lrupr_pkg::rsp_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: result with no request pending: %s", $realtime, show(got));
        return;
      end
      want = owed.pop_front();
      if (got.hit !== want.hit || got.frame_slot !== want.frame_slot ||
          got.evicted_valid !== want.evicted_valid ||
          got.evicted_page !== want.evicted_page ||
          got.fault_total !== want.fault_total || got.run_end !== want.run_end) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid;
  logic            in_stall;
  lrupr_pkg::req_t in_req;
  logic            out_valid;
  logic            out_stall;
  lrupr_pkg::rsp_t out_rsp;
  logic            psel;
  logic            penable;
  logic            pwrite;
  logic [2:0]      paddr;
  logic [31:0]     pwdata;
  logic [31:0]     prdata;
  logic            pready;

  page_table_scoreboard sb;

  // Largest gap each side may draw per request; zero turns idling off.
  int send_gap_max = MAX_IDLE;
  int stall_max    = MAX_IDLE;
  int quiet_cycles = 0;

  lru_page_replacement_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one request after a random gap, hold it until the block takes it,
  // then book the expected result. Valid stays high when the next gap is zero.
  task automatic send_request(input bit [7:0] pg, input bit last);
    int              gap;
    lrupr_pkg::req_t req;
    gap          = $urandom_range(send_gap_max);
    req.page     = pg;
    req.last_ref = last;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_request(req);
  endtask

  // Drop valid and wait until every owed result is out, plus a margin for the
  // two pipeline stages, so the block is idle before a register write.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the write lands at the edge with pready high.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(addr, data);
  endtask

  task automatic set_frames(input int count);
    settle();
    write_reg(FRAMES_USED_ADDR, 32'(count));
  endtask

  // Result side: stall for a random number of cycles per result, then release
  // and check whatever the block hands over.
  initial begin
    int hold;
    out_stall <= 1'b1;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = $urandom_range(stall_max);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      sb.check_result(out_rsp);
    end
  end

  // Count cycles with no handshake on either channel; a stuck block ends here.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL lru_page_replacement_unit");
      $finish;
    end
  end

  initial begin
    int       sent;
    int       count;
    int       span;
    bit [7:0] base;
    bit [7:0] pg;
    bit       last;
    sb       = new();
    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    in_req   <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Run on the reset frame count: fill all four frames with a hit among the fills, then
    // evict the oldest twice. End one run on a hit and a second, one-request run on a miss.
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'h5A, 1'b0);
    send_request(8'hA5, 1'b0);
    send_request(8'h3C, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'h5A, 1'b0);
    send_request(8'h3C, 1'b1);
    send_request(8'h80, 1'b1);

    // A write past the register list must leave the frame count alone.
    settle();
    write_reg(UNMAPPED_ADDR, 32'd1);
    send_request(8'h01, 1'b0);
    send_request(8'h02, 1'b0);
    send_request(8'h03, 1'b0);
    send_request(8'h04, 1'b0);

    // Shrink the table mid-run: the upper frames keep their pages but drop out
    // of the search, so page 4 lands twice once the table grows back, and the
    // lowest copy must win.
    set_frames(2);
    send_request(8'h04, 1'b0);
    send_request(8'h03, 1'b0);
    set_frames(NUM_FRAMES);
    send_request(8'h04, 1'b0);
    send_request(8'h03, 1'b0);
    send_request(8'h01, 1'b1);

    // Zero frames behaves as one.
    set_frames(0);
    send_request(8'h07, 1'b0);
    send_request(8'h07, 1'b0);
    send_request(8'h09, 1'b1);

    // Oversized count behaves as four. Cycle through fresh pages with idling
    // off so every request faults and, past the fill, evicts.
    set_frames(7);
    send_gap_max = 0;
    stall_max    = 0;
    for (int i = 0; i < OVERSIZE_REQS; i++) send_request(8'(i), i == OVERSIZE_REQS - 1);

    // Random phases: each picks a frame count and idling, then mostly replays a
    // small working set so hits, evictions and run ends all show up; the rest
    // is scattered pages. Runs carry across frame count changes.
    sent = 0;
    while (sent < RANDOM_REQS) begin
      set_frames($urandom_range(7));
      send_gap_max = ($urandom_range(3) == 0) ? 0 : MAX_IDLE;
      stall_max    = ($urandom_range(3) == 0) ? 0 : MAX_IDLE;
      count        = $urandom_range(120, 20);
      base         = 8'($urandom);
      span         = $urandom_range(6, 1);
      for (int k = 0; k < count; k++) begin
        if ($urandom_range(99) < 85) begin
          pg   = 8'(base + $urandom_range(span - 1));
          last = ($urandom_range(24) == 0);
          if (last) begin
            base = 8'($urandom);
            span = $urandom_range(6, 1);
          end
        end else begin
          pg   = 8'($urandom);
          last = ($urandom_range(7) == 0);
        end
        send_request(pg, last);
        sent++;
      end
    end

    // Drain, then give the pipeline time to show any stray result.
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("PASS lru_page_replacement_unit");
    end else begin
      $display("FAIL lru_page_replacement_unit");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lrupr_pkg.sv
rtl/core/lrupr_frame_table.sv
rtl/core/lru_page_replacement_unit.sv
rtl/core/lrupr_checker.sv
tb/tb_top.sv
